/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL. Synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* hdl/gl1pm_pkg.sv */
`default_nettype none

package gl1pm_pkg;

  localparam int MAX_POINTS_DEF = 256;
  localparam int COORD_W        = 16;
  localparam int DIST_W         = 17;
  localparam int OP_W           = 2;

  localparam logic [DIST_W-1:0] THRESH_RESET = 17'd160;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
  localparam logic [OP_W-1:0] OP_MATCH = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // One stored candidate as it sits in a cell of the ring.
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      used;
  } cand_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic mark;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic start;
    logic valid;
  } scan_ctrl_t;

endpackage

`default_nettype wire

/* hdl/gl1pm_cell.sv */
`default_nettype none

module gl1pm_cell (
  input  wire                                  clk,
  input  wire                                  rst,
  input  gl1pm_pkg::cell_ctrl_t                ctrl,
  input  wire signed [gl1pm_pkg::COORD_W-1:0]  load_x,
  input  wire signed [gl1pm_pkg::COORD_W-1:0]  load_y,
  input  gl1pm_pkg::cand_t                     nxt,
  output gl1pm_pkg::cand_t                     cur
);
  import gl1pm_pkg::*;

  logic signed [COORD_W-1:0] x;
  logic signed [COORD_W-1:0] y;
  logic                      used;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      x <= nxt.x;
      y <= nxt.y;
    end else if (ctrl.load) begin
      x <= load_x;
      y <= load_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else begin
      priority if (ctrl.clear) begin
        used <= 1'b0;
      end else if (ctrl.shift) begin
        used <= nxt.used;
      end else if (ctrl.load) begin
        used <= 1'b0;
      end else if (ctrl.mark) begin
        used <= 1'b1;
      end
    end
  end

  assign cur.x    = x;
  assign cur.y    = y;
  assign cur.used = used;

endmodule

`default_nettype wire

/* hdl/gl1pm_dist.sv */
`default_nettype none

module gl1pm_dist #(
  parameter int IDX_W = 8
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  gl1pm_pkg::scan_ctrl_t                ctrl,
  input  gl1pm_pkg::cand_t                     head,
  input  wire                                  in_range,
  input  wire [IDX_W-1:0]                      idx,
  input  wire signed [gl1pm_pkg::COORD_W-1:0]  qx,
  input  wire signed [gl1pm_pkg::COORD_W-1:0]  qy,
  input  wire [gl1pm_pkg::DIST_W-1:0]          threshold,
  output logic                                 found,
  output logic [IDX_W-1:0]                     best_idx,
  output logic [gl1pm_pkg::DIST_W-1:0]         best_dist
);
  import gl1pm_pkg::*;

  logic [COORD_W:0]   dx;
  logic [COORD_W:0]   dy;
  logic [COORD_W:0]   adx;
  logic [COORD_W:0]   ady;
  logic [DIST_W-1:0]  l1_sum;

  logic               v_reg;
  logic               ok_reg;
  logic [IDX_W-1:0]   idx_reg;
  logic [DIST_W-1:0]  d_reg;
  logic               take;

  // The differences of two 16-bit values need 17 bits; their magnitudes fit in 16.
  assign dx     = {qx[COORD_W-1], qx} - {head.x[COORD_W-1], head.x};
  assign dy     = {qy[COORD_W-1], qy} - {head.y[COORD_W-1], head.y};
  assign adx    = dx[COORD_W] ? ((COORD_W+1)'(0) - dx) : dx;
  assign ady    = dy[COORD_W] ? ((COORD_W+1)'(0) - dy) : dy;
  assign l1_sum = {1'b0, adx[COORD_W-1:0]} + {1'b0, ady[COORD_W-1:0]};

  always_ff @(posedge clk) begin
    idx_reg <= idx;
    d_reg   <= l1_sum;
    ok_reg  <= in_range && !head.used;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_reg <= 1'b0;
    end else begin
      v_reg <= ctrl.valid;
    end
  end

  // Strict compare against the best keeps the lower index on ties.
  assign take = v_reg && ok_reg && (d_reg < threshold) && (!found || d_reg < best_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      found     <= 1'b0;
      best_idx  <= '0;
      best_dist <= '0;
    end else if (ctrl.start) begin
      found     <= 1'b0;
      best_idx  <= '0;
      best_dist <= '0;
    end else if (take) begin
      found     <= 1'b1;
      best_idx  <= idx_reg;
      best_dist <= d_reg;
    end
  end

endmodule

`default_nettype wire

/* hdl/greedy_l1_point_matcher.sv */
// Channel  | Direction | Contents
// s_axis   | in        | tuser: opcode[1:0]; tdata: point_x[15:0], point_y[31:16]
// m_axis   | out       | tuser: match_found[0], load_overflow[1];
//          |           | tdata: query_index[7:0], match_index[15:8], match_distance[32:16]
// cfg      | in        | cfg_wr_en, cfg_wr_data = match_threshold
//
// Clear, load and unused opcodes are answered straight from the idle state. A query
// rotates the candidate ring one full turn, one candidate per cycle through the head
// cell and a two-stage distance and compare unit, then reports once the output is free.
// Reset (rst, synchronous) clears the used marks, step, cand and query counters and
// the output valid, and sets the threshold to 160. Stored coordinates are not cleared.
// A result waits in the output register; no item is accepted until it is taken.
`include "assert_macros.svh"

`default_nettype none

module greedy_l1_point_matcher #(
  parameter int MAX_POINTS = gl1pm_pkg::MAX_POINTS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire [31:0]                          s_axis_tdata,  // point_x, point_y
  input  wire [1:0]                           s_axis_tuser,  // opcode
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [39:0]                         m_axis_tdata,  // query_index, match_index,
                                                             // match_distance, zero pad
  output logic [1:0]                          m_axis_tuser,  // match_found, load_overflow
  input  wire                                 cfg_wr_en,
  input  wire [gl1pm_pkg::DIST_W-1:0]         cfg_wr_data
);
  import gl1pm_pkg::*;

  localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0] STEP_END = CNT_W'(MAX_POINTS - 1);
  localparam logic [IDX_W-1:0] QC_END   = IDX_W'(MAX_POINTS - 1);

  state_t                    state;
  state_t                    state_next;
  logic [CNT_W-1:0]          step;
  logic [CNT_W-1:0]          cand_count;
  logic [IDX_W-1:0]          query_count;
  logic signed [COORD_W-1:0] qx;
  logic signed [COORD_W-1:0] qy;
  logic [DIST_W-1:0]         match_threshold;

  logic                      out_found;
  logic [7:0]                out_qidx;
  logic [7:0]                out_midx;
  logic [DIST_W-1:0]         out_dist;
  logic                      out_ovf;

  logic                      out_free;
  logic                      accept;
  logic                      shift;
  logic                      done_we;
  logic                      produce;
  logic [OP_W-1:0]           op;
  logic                      room;
  logic                      ld_ok;

  logic                      found;
  logic [IDX_W-1:0]          best_idx;
  logic [DIST_W-1:0]         best_dist;
  logic [IDX_W+7:0]          qc_wide;
  logic [IDX_W+7:0]          bi_wide;

  cand_t                     cells [MAX_POINTS];
  cell_ctrl_t                cctrl [MAX_POINTS];
  scan_ctrl_t                sctrl;

  assign op       = s_axis_tuser;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign room     = cand_count < CNT_MAX;
  assign ld_ok    = accept && (op == OP_LOAD) && room;
  assign produce  = (accept && (op != OP_MATCH)) || done_we;
  assign s_axis_tready = (state == ST_IDLE) && out_free;

  always_comb begin
    state_next = state;
    accept     = 1'b0;
    shift      = 1'b0;
    done_we    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        accept = s_axis_tvalid && out_free;
        if (accept && (op == OP_MATCH)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        shift = 1'b1;
        if (step == STEP_END) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          done_we    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      step            <= '0;
      cand_count      <= '0;
      query_count     <= '0;
      match_threshold <= THRESH_RESET;
      m_axis_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        match_threshold <= cfg_wr_data;
      end
      if (accept && (op == OP_CLEAR)) begin
        cand_count  <= '0;
        query_count <= '0;
      end
      if (ld_ok) begin
        cand_count <= cand_count + CNT_W'(1);
      end
      if (accept && (op == OP_MATCH)) begin
        step <= '0;
      end else if (shift) begin
        step <= step + CNT_W'(1);
      end
      if (done_we) begin
        query_count <= (query_count == QC_END) ? '0 : query_count + IDX_W'(1);
      end
      if (produce) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (op == OP_MATCH)) begin
      qx <= s_axis_tdata[15:0];
      qy <= s_axis_tdata[31:16];
    end
  end

  assign qc_wide = {8'd0, query_count};
  assign bi_wide = {8'd0, best_idx};

  always_ff @(posedge clk) begin
    if (done_we) begin
      out_found <= found;
      out_qidx  <= qc_wide[7:0];
      out_midx  <= found ? bi_wide[7:0] : 8'd0;
      out_dist  <= found ? best_dist : '0;
      out_ovf   <= 1'b0;
    end else if (produce) begin
      out_found <= 1'b0;
      out_qidx  <= 8'd0;
      out_midx  <= 8'd0;
      out_dist  <= '0;
      out_ovf   <= (op == OP_LOAD) && !room;
    end
  end

  assign m_axis_tdata = {7'd0, out_dist, out_midx, out_qidx};
  assign m_axis_tuser = {out_ovf, out_found};

  // The ring turns toward cell 0, which is the head seen by the distance unit.
  // After a full turn every candidate is back at its own position.
  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
    localparam int NXT = (i + 1) % MAX_POINTS;

    assign cctrl[i].shift = shift;
    assign cctrl[i].clear = accept && (op == OP_CLEAR);
    assign cctrl[i].load  = ld_ok && (cand_count[IDX_W-1:0] == IDX_W'(i));
    assign cctrl[i].mark  = done_we && found && (best_idx == IDX_W'(i));

    gl1pm_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (cctrl[i]),
      .load_x (s_axis_tdata[15:0]),
      .load_y (s_axis_tdata[31:16]),
      .nxt    (cells[NXT]),
      .cur    (cells[i])
    );
  end

  assign sctrl.start = accept && (op == OP_MATCH);
  assign sctrl.valid = shift;

  gl1pm_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (sctrl),
    .head      (cells[0]),
    .in_range  (step < cand_count),
    .idx       (step[IDX_W-1:0]),
    .qx        (qx),
    .qy        (qy),
    .threshold (match_threshold),
    .found     (found),
    .best_idx  (best_idx),
    .best_dist (best_dist)
  );

  `ASSERT_IMPLIES(a_count_bound, clk, rst, 1'b1, cand_count <= CNT_MAX)
  `ASSERT_NEXT(a_scan_end, clk, rst, (state == ST_SCAN) && (step == STEP_END), state == ST_DRAIN)
  `ASSERT_NEXT(a_done_out, clk, rst, done_we, m_axis_tvalid && (state == ST_IDLE))
  `ASSERT_IMPLIES(a_scan_step, clk, rst, state == ST_SCAN, step < CNT_MAX)

endmodule

`default_nettype wire
